### src/sai_pkg.sv
package sai_pkg;

  // Pool defaults
  localparam int SLOTS_DEFAULT = 1024;
  localparam int MAX_NUMBERS_W = 11;
  localparam logic [MAX_NUMBERS_W-1:0] MAX_NUMBERS_RESET = 11'd1024;

  // Word field widths
  localparam int REQ_TYPE_W = 2;
  localparam int SLOT_W     = 10;

  // Request kinds
  localparam logic [REQ_TYPE_W-1:0] REQ_GET     = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_CHECK   = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 2'd2;

  typedef struct packed {
    logic [REQ_TYPE_W-1:0] req_type;
    logic [SLOT_W-1:0]     slot_number;
  } req_t;

  typedef struct packed {
    logic              success;
    logic [SLOT_W-1:0] granted_id;
  } rsp_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

endpackage

### src/slot_id_allocator.sv
// A request accepted when idle reads the free map and the reuse stack; no new request is taken
// until it finishes. Its result word and each memory write-back (separate read and write
// ports) are registered as the execute state ends, which waits while the output is stalled.
// Reset clears the state, stack count, watermark and output valid; max_numbers returns to 1024.
// No clearing pass: map entries at or above the watermark always read as free.
module slot_id_allocator import sai_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_stall,
  input  req_t                     req,
  output logic                     rsp_valid,
  input  logic                     rsp_stall,
  output rsp_t                     rsp,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [MAX_NUMBERS_W-1:0] cfg_data
);

  localparam int IDW = $clog2(SLOTS);
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int LW  = (CW > MAX_NUMBERS_W) ? CW : MAX_NUMBERS_W;
  localparam logic [LW-1:0] SLOTS_L = LW'(SLOTS);

  state_t state;
  state_t state_next;

  req_t                     req_q;
  logic [CW-1:0]            stack_count;
  logic [CW-1:0]            stack_count_next;
  logic [CW-1:0]            fresh_next;
  logic [CW-1:0]            fresh_next_next;
  logic [MAX_NUMBERS_W-1:0] max_numbers;
  logic                     rsp_valid_next;
  rsp_t                     rsp_next;

  // Memory ports
  logic           rd_en;
  logic           map_we;
  logic [IDW-1:0] map_waddr;
  logic           map_wdata;
  logic           map_rdata;
  logic           stack_we;
  logic [IDW-1:0] stack_waddr;
  logic [IDW-1:0] stack_wdata;
  logic [IDW-1:0] stack_rdata;
  logic [IDW-1:0] stack_raddr;
  logic [IDW-1:0] in_slot_idx;
  logic [CW-1:0]  count_m1;
  logic [LW-1:0]  in_slot_ext;

  // Execute-stage terms
  logic [LW-1:0]  slot_ext;
  logic [LW-1:0]  fresh_ext;
  logic [LW-1:0]  count_ext;
  logic [LW-1:0]  max_ext;
  logic [LW-1:0]  id_ext;
  logic [IDW-1:0] slot_idx;
  logic           slot_ok;
  logic           slot_free;
  logic           fresh_ok;
  logic           stack_has;
  logic           done;

  // Free map: one bit per slot, entries below the watermark are live
  sai_ram #(
    .WIDTH (1),
    .DEPTH (SLOTS)
  ) u_free_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (rd_en),
    .raddr (in_slot_idx),
    .rdata (map_rdata)
  );

  // Reuse stack of released IDs
  sai_ram #(
    .WIDTH (IDW),
    .DEPTH (SLOTS)
  ) u_reuse_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .re    (rd_en),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_numbers <= MAX_NUMBERS_RESET;
    end else if (cfg_valid) begin
      max_numbers <= cfg_data;
    end
  end

  // Read addresses from the incoming word and the stack top
  assign in_slot_ext = {{(LW-SLOT_W){1'b0}}, req.slot_number};
  assign in_slot_idx = in_slot_ext[IDW-1:0];
  assign count_m1    = stack_count - CW'(1);
  assign stack_raddr = count_m1[IDW-1:0];

  // Finish the item once the output register can take the result
  assign done = (state == ST_EXEC) && !(rsp_valid && rsp_stall);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    req_stall = 1'b1;
    rd_en     = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        rd_en     = req_valid;
      end
      ST_EXEC: begin
        req_stall = 1'b1;
        rd_en     = 1'b0;
      end
      default: begin
        req_stall = 1'b1;
        rd_en     = 1'b0;
      end
    endcase
  end

  // Operand compares against the effective pool limit
  assign slot_ext  = {{(LW-SLOT_W){1'b0}}, req_q.slot_number};
  assign slot_idx  = slot_ext[IDW-1:0];
  assign fresh_ext = {{(LW-CW){1'b0}}, fresh_next};
  assign count_ext = {{(LW-CW){1'b0}}, stack_count};
  assign max_ext   = {{(LW-MAX_NUMBERS_W){1'b0}}, max_numbers};
  assign id_ext    = {{(LW-IDW){1'b0}}, stack_rdata};
  assign slot_ok   = (slot_ext < max_ext) && (slot_ext < SLOTS_L);
  assign slot_free = (slot_ext >= fresh_ext) || map_rdata;
  assign fresh_ok  = (fresh_ext < max_ext) && (fresh_ext < SLOTS_L);
  assign stack_has = (stack_count != '0);

  // Modify and write back
  always_comb begin
    map_we           = 1'b0;
    map_waddr        = slot_idx;
    map_wdata        = 1'b0;
    stack_we         = 1'b0;
    stack_waddr      = stack_count[IDW-1:0];
    stack_wdata      = slot_idx;
    stack_count_next = stack_count;
    fresh_next_next  = fresh_next;
    rsp_next         = '0;
    case (req_q.req_type)
      REQ_GET: begin
        if (stack_has) begin
          map_we               = done;
          map_waddr            = stack_rdata;
          stack_count_next     = count_m1;
          rsp_next.success     = 1'b1;
          rsp_next.granted_id  = id_ext[SLOT_W-1:0];
        end else if (fresh_ok) begin
          map_we               = done;
          map_waddr            = fresh_next[IDW-1:0];
          fresh_next_next      = fresh_next + CW'(1);
          rsp_next.success     = 1'b1;
          rsp_next.granted_id  = fresh_ext[SLOT_W-1:0];
        end
      end
      REQ_CHECK: begin
        rsp_next.success = slot_ok && slot_free;
      end
      REQ_RELEASE: begin
        if (slot_ok && !slot_free && (count_ext < SLOTS_L)) begin
          map_we           = done;
          map_wdata        = 1'b1;
          stack_we         = done;
          stack_count_next = stack_count + CW'(1);
        end
      end
      default: begin
        rsp_next = '0;
      end
    endcase
  end

  // Output word valid: load on finish, drop when taken
  always_comb begin
    rsp_valid_next = rsp_valid;
    if (done) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      stack_count <= '0;
      fresh_next  <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
      if (done) begin
        stack_count <= stack_count_next;
        fresh_next  <= fresh_next_next;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rd_en) begin
      req_q <= req;
    end
    if (done) begin
      rsp <= rsp_next;
    end
  end

endmodule

### src/sai_ram.sv
module sai_ram import sai_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = SLOTS_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data when not reading
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import sai_pkg::*;

  localparam int SLOTS = SLOTS_DEFAULT;
  localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 60;
  localparam int STUCK_LIMIT = 4000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  req_t                     req = '0;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  rsp_t                     rsp;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [MAX_NUMBERS_W-1:0] cfg_data = '0;

  slot_id_allocator #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Allocator state as the testbench sees it
  bit                       slot_free [SLOTS];
  logic [SLOT_W-1:0]        reuse_ids [SLOTS];
  int unsigned              reuse_depth = 0;
  int unsigned              watermark = 0;
  logic [MAX_NUMBERS_W-1:0] max_reg = MAX_NUMBERS_RESET;

  rsp_t outcome_q[$];
  int   errors = 0;
  int   snd_pct = 0;
  int   rcv_pct = 0;
  int   holds_asked = 0;
  int   holds_served = 0;
  int   hold_left = 0;
  int   stuck_cycles = 0;

  // Directed plan: either a register write or a request with an optional typed answer
  typedef struct {
    bit                       is_cfg;
    logic [MAX_NUMBERS_W-1:0] cfg_value;
    req_t                     word;
    bit                       known;
    rsp_t                     want;
  } plan_row_t;

  plan_row_t plan[$];

  initial begin
    foreach (slot_free[i]) slot_free[i] = 1'b1;
  end

  function automatic int unsigned pool_size();
    return (max_reg > SLOTS) ? SLOTS : max_reg;
  endfunction

  // Apply one request to the tracked state and return the word it must produce
  function automatic rsp_t alloc_outcome(input req_t w);
    rsp_t        r;
    int unsigned lim;
    lim = pool_size();
    r = '0;
    case (w.req_type)
      REQ_GET: begin
        if (reuse_depth > 0) begin
          reuse_depth--;
          r.granted_id = reuse_ids[reuse_depth];
          slot_free[r.granted_id] = 1'b0;
          r.success = 1'b1;
        end else if (watermark < lim) begin
          slot_free[watermark] = 1'b0;
          r.granted_id = watermark[SLOT_W-1:0];
          r.success = 1'b1;
          watermark++;
        end
      end
      REQ_CHECK: begin
        if (w.slot_number < lim) r.success = slot_free[w.slot_number];
      end
      REQ_RELEASE: begin
        if (w.slot_number < lim && !slot_free[w.slot_number] && reuse_depth < SLOTS) begin
          slot_free[w.slot_number] = 1'b1;
          reuse_ids[reuse_depth] = w.slot_number;
          reuse_depth++;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic void add_req(input logic [REQ_TYPE_W-1:0] kind,
                                  input logic [SLOT_W-1:0] slot, input bit known,
                                  input logic ok, input logic [SLOT_W-1:0] id);
    plan_row_t row;
    row = '{default: '0};
    row.word.req_type = kind;
    row.word.slot_number = slot;
    row.known = known;
    row.want.success = ok;
    row.want.granted_id = id;
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(input logic [MAX_NUMBERS_W-1:0] value);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_value = value;
    plan.push_back(row);
  endfunction

  // Prefer an ID that is currently handed out, so releases land
  function automatic logic [SLOT_W-1:0] pick_taken();
    logic [SLOT_W-1:0] s;
    s = SLOT_W'($urandom_range(SLOTS - 1));
    if (watermark == 0) return s;
    for (int k = 0; k < 8; k++) begin
      s = SLOT_W'($urandom_range(watermark - 1));
      if (!slot_free[s]) return s;
    end
    return s;
  endfunction

  function automatic req_t random_request();
    req_t w;
    int   r;
    r = $urandom_range(99);
    w.slot_number = SLOT_W'($urandom_range(SLOTS - 1));
    if (r < 42) begin
      w.req_type = REQ_GET;
    end else if (r < 62) begin
      w.req_type = REQ_CHECK;
      if ($urandom_range(1)) w.slot_number = pick_taken();
    end else if (r < 97) begin
      w.req_type = REQ_RELEASE;
      if ($urandom_range(99) < 80) w.slot_number = pick_taken();
    end else begin
      w.req_type = REQ_UNUSED;
    end
    return w;
  endfunction

  task automatic wait_drained();
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  // Offer one word, hold it until taken, then record its expected answer
  task automatic send_word(input req_t w, input bit known, input rsp_t typed);
    rsp_t predicted;
    while ($urandom_range(99) < snd_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = alloc_outcome(w);
    outcome_q.push_back(known ? typed : predicted);
  endtask

  // Change the pool size only once every answer is back
  task automatic write_max(input logic [MAX_NUMBERS_W-1:0] value);
    req_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    max_reg = value;
  endtask

  task automatic random_run(input logic [MAX_NUMBERS_W-1:0] value, input int count,
                            input int sp, input int rp, input bit hold_off,
                            input bit pause_mid);
    write_max(value);
    snd_pct = sp;
    rcv_pct <= rp;
    if (hold_off) holds_asked <= holds_asked + 1;
    for (int n = 0; n < count; n++) begin
      if (pause_mid && n == count / 2) begin
        req_valid <= 1'b0;
        wait_drained();
      end
      send_word(random_request(), 1'b0, '0);
    end
  endtask

  // Receiver side: random stall, or a long hold-off when one is asked for
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_asked > holds_served) begin
      rsp_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      holds_served <= holds_served + 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < rcv_pct);
    end
  end

  // Compare each taken answer word with the oldest expectation
  always @(posedge clk) begin : check_answers
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual success %0b id %0d",
                 $time, rsp.success, rsp.granted_id);
        errors++;
      end else begin
        want = outcome_q[0];
        outcome_q.delete(0);
        if (rsp.success !== want.success) begin
          $display("%0t: success mismatch: expected %0b, actual %0b",
                   $time, want.success, rsp.success);
          errors++;
        end
        if (rsp.granted_id !== want.granted_id) begin
          $display("%0t: granted_id mismatch: expected %0d, actual %0d",
                   $time, want.granted_id, rsp.granted_id);
          errors++;
        end
      end
    end
  end

  // Give up when nothing moves for too long
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    // Fresh pool: all free, watermark handout, LIFO reuse
    add_req(REQ_CHECK,   10'd0,    1'b1, 1'b1, 10'd0);
    add_req(REQ_CHECK,   10'd1023, 1'b1, 1'b1, 10'd0);
    add_req(REQ_RELEASE, 10'd1023, 1'b1, 1'b0, 10'd0);
    add_req(REQ_UNUSED,  10'd1023, 1'b1, 1'b0, 10'd0);
    add_req(REQ_GET,     10'd1023, 1'b1, 1'b1, 10'd0);
    add_req(REQ_GET,     10'd0,    1'b1, 1'b1, 10'd1);
    add_req(REQ_GET,     10'd0,    1'b1, 1'b1, 10'd2);
    add_req(REQ_CHECK,   10'd1,    1'b1, 1'b0, 10'd0);
    add_req(REQ_RELEASE, 10'd1,    1'b1, 1'b0, 10'd0);
    add_req(REQ_RELEASE, 10'd2,    1'b1, 1'b0, 10'd0);
    add_req(REQ_CHECK,   10'd1,    1'b0, 1'b0, 10'd0);
    add_req(REQ_GET,     10'd0,    1'b1, 1'b1, 10'd2);
    // Shrink the pool: stack still serves, watermark exhausted, limit edge
    add_cfg(11'd3);
    add_req(REQ_GET,     10'd0,    1'b1, 1'b1, 10'd1);
    add_req(REQ_GET,     10'd0,    1'b1, 1'b0, 10'd0);
    add_req(REQ_CHECK,   10'd3,    1'b1, 1'b0, 10'd0);
    add_req(REQ_RELEASE, 10'd3,    1'b1, 1'b0, 10'd0);
    add_req(REQ_RELEASE, 10'd0,    1'b1, 1'b0, 10'd0);
    // Empty pool: releases ignored, stacked ID still granted
    add_cfg(11'd0);
    add_req(REQ_RELEASE, 10'd2,    1'b1, 1'b0, 10'd0);
    add_req(REQ_GET,     10'd0,    1'b1, 1'b1, 10'd0);
    add_req(REQ_GET,     10'd0,    1'b1, 1'b0, 10'd0);
    add_req(REQ_CHECK,   10'd0,    1'b1, 1'b0, 10'd0);
    // Oversized register clamps to the full pool
    add_cfg(11'd2047);
    add_req(REQ_GET,     10'd0,    1'b1, 1'b1, 10'd3);
    add_req(REQ_CHECK,   10'd1023, 1'b1, 1'b1, 10'd0);
    add_req(REQ_RELEASE, 10'd2,    1'b0, 1'b0, 10'd0);
    add_req(REQ_GET,     10'd0,    1'b0, 1'b0, 10'd0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        write_max(plan[i].cfg_value);
      else
        send_word(plan[i].word, plan[i].known, plan[i].want);
    end

    random_run(11'd8,    150, 25, 51, 1'b0, 1'b0);
    random_run(11'd1,     80, 51, 25, 1'b0, 1'b0);
    random_run(11'd16,   150,  0,  0, 1'b1, 1'b0);
    random_run(MAX_NUMBERS_W'($urandom_range(1024, 1)), 150, 25, 51, 1'b0, 1'b1);
    random_run(11'd1024, 220, 51, 25, 1'b0, 1'b0);
    random_run(11'd2047, 150,  0,  0, 1'b0, 1'b0);

    req_valid <= 1'b0;
    wait_drained();
    repeat (4) @(posedge clk);
    if (errors == 0 && outcome_q.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule

### slot_id_allocator.f
src/sai_pkg.sv
src/sai_ram.sv
src/slot_id_allocator.sv
tb/testbench.sv
